@@ src/psd_pkg.sv @@
// Package for the pair sort and dedup block.
// Holds the controller state type and the command and status bundles
// between the controller and the datapath. It depends on nothing.
package psd_pkg;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_word;
	} status_t;

endpackage

@@ src/psd_ctrl.sv @@
// Controller of the pair sort and dedup block.
// Sequences collection and output of a list and drives both handshakes.
// Depends on psd_pkg.
module psd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_pair,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  psd_pkg::status_t status,
	output psd_pkg::cmd_t    cmd
);
	import psd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   in_acc;
	logic   out_acc;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	assign cmd.insert = in_acc;
	assign cmd.shift  = out_acc;
	assign cmd.clear  = out_acc && status.final_word;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && last_pair) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_acc && status.final_word) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/psd_datapath.sv @@
// Datapath of the pair sort and dedup block: a sorted row of pair cells
// with a fill count and an overflow flag, plus the result word mux.
// Depends on psd_pkg.
module psd_datapath #(
	parameter int CAPACITY = 64,
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psd_pkg::cmd_t       cmd,
	output psd_pkg::status_t    status,
	input  logic [ID_WIDTH-1:0] first_id,
	input  logic [ID_WIDTH-1:0] second_id,
	output logic [ID_WIDTH-1:0] low_id,
	output logic [ID_WIDTH-1:0] high_id,
	output logic                pair_valid,
	output logic                last_out,
	output logic                overflow
);
	import psd_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = 2 * ID_WIDTH;

	logic [KW-1:0]       cell_q [CAPACITY];
	logic [CW-1:0]       count_q;
	logic                overflow_q;

	logic                good;
	logic [KW-1:0]       key;
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic                dup;
	logic                full;
	logic                do_ins;
	logic                set_ovf;

	// A pair survives only with two distinct, present members.
	assign good = (first_id != '0) && (second_id != '0) && (first_id != second_id);
	assign key  = (first_id < second_id) ? {first_id, second_id} : {second_id, first_id};

	// Every occupied cell is compared with the new key at once.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (count_q > CW'(i)) && (cell_q[i] < key);
			eq[i] = (count_q > CW'(i)) && (cell_q[i] == key);
		end
	end

	assign dup     = |eq;
	assign full    = (count_q == CW'(CAPACITY));
	assign do_ins  = cmd.insert && good && !dup && !full;
	assign set_ovf = cmd.insert && good && !dup && full;

	// Each cell keeps its pair, takes the key, or takes its lower neighbor,
	// which opens a gap at the insertion point. While emitting, the row
	// shifts toward cell zero.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic prev_lt;
		if (g == 0) begin : g_first
			assign prev_lt = 1'b1;
		end else begin : g_rest
			assign prev_lt = lt[g-1];
		end

		always_ff @(posedge clk) begin
			if (do_ins && !lt[g]) begin
				if (prev_lt) begin
					cell_q[g] <= key;
				end else if (g > 0) begin
					cell_q[g] <= cell_q[(g > 0) ? g - 1 : 0];
				end
			end else if (cmd.shift && (g < CAPACITY - 1)) begin
				cell_q[g] <= cell_q[(g < CAPACITY - 1) ? g + 1 : g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.shift && (count_q != '0)) begin
				count_q <= count_q - CW'(1);
			end
			if (set_ovf) begin
				overflow_q <= 1'b1;
			end
		end
	end

	assign status.final_word = (count_q <= CW'(1));

	assign pair_valid = (count_q != '0);
	assign low_id     = pair_valid ? cell_q[0][KW-1:ID_WIDTH] : '0;
	assign high_id    = pair_valid ? cell_q[0][ID_WIDTH-1:0] : '0;
	assign last_out   = status.final_word;
	assign overflow   = overflow_q;

endmodule

@@ src/pair_sort_dedup.sv @@
// Top level of the pair sort and dedup block.
// Joins the controller (psd_ctrl) and the datapath (psd_datapath).
// Depends on psd_pkg.
//
// Usage: candidate pairs arrive on the input channel (in_valid/in_ready),
// one word per cycle while the block is collecting a list. Each word is made
// canonical, pairs with a missing or repeated member are dropped, and the
// rest are placed into a sorted row of CAPACITY cells in the same cycle;
// an exact duplicate of a stored pair is ignored. The row compares every
// occupied cell with the new pair in parallel.
// The word marked last_pair ends the list. From the next cycle on, in_ready
// is low and the sorted unique pairs appear on the output channel
// (out_valid/out_ready), one word per cycle while out_ready is high, as the row
// shifts toward its head, the final one with last_out high. An empty list gives a
// single word with pair_valid low and last_out high. The overflow output tells
// whether pairs of this list were dropped because the row was full.
// A stall of the receiver holds the current output word and the row in place.
// Reset empties the row, clears the overflow flag and starts collecting.
module pair_sort_dedup #(
	parameter int CAPACITY = 64,
	parameter int ID_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ID_WIDTH-1:0] first_id,
	input  logic [ID_WIDTH-1:0] second_id,
	input  logic                last_pair,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ID_WIDTH-1:0] low_id,
	output logic [ID_WIDTH-1:0] high_id,
	output logic                pair_valid,
	output logic                last_out,
	output logic                overflow
);
	import psd_pkg::*;

	cmd_t    cmd;
	status_t status;

	psd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_pair (last_pair),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	psd_datapath #(
		.CAPACITY (CAPACITY),
		.ID_WIDTH (ID_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.first_id   (first_id),
		.second_id  (second_id),
		.low_id     (low_id),
		.high_id    (high_id),
		.pair_valid (pair_valid),
		.last_out   (last_out),
		.overflow   (overflow)
	);

endmodule

@@ src/psd_checker.sv @@
// Port-level checker for the pair sort and dedup block, bound to its top.
// Watches only the top level's ports. Depends on nothing else.
module psd_checker #(
	parameter int ID_WIDTH = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [ID_WIDTH-1:0] low_id,
	input logic [ID_WIDTH-1:0] high_id,
	input logic                pair_valid,
	input logic                last_out
);

	// A held output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(low_id) && $stable(high_id)
		&& $stable(last_out))
		else $error("output word changed while stalled");

	// No new list is taken while one is draining.
	a_one_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while emitting");

	// The empty-list word is always the final word.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pair_valid |-> last_out)
		else $error("empty word not marked last");

	// Emitted pairs are canonical and present.
	a_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_valid |-> (low_id != '0) && (low_id < high_id))
		else $error("pair not canonical");

	// A list drains without gaps until its final word.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=> out_valid)
		else $error("output gap inside a list");

endmodule

bind pair_sort_dedup psd_checker #(.ID_WIDTH(ID_WIDTH)) u_psd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.low_id     (low_id),
	.high_id    (high_id),
	.pair_valid (pair_valid),
	.last_out   (last_out)
);
